// ===== rtl/ebml_pkg.sv =====
// shared types, element ids and the varint length helper function for the ebml element stream parser
package ebml_pkg;

   typedef enum logic [2:0] {
      KIND_CONTAINER = 3'd0,
      KIND_SKIPPED   = 3'd1,
      KIND_UNSIGNED  = 3'd2,
      KIND_FLOAT     = 3'd3,
      KIND_ERROR     = 3'd4
   } kind_type;

   typedef struct packed {
      logic [31:0] hdr_id;
      logic [31:0] payload_size;
      logic [31:0] element_value;
      kind_type    kind;
      logic        is_video_name;
   } result_type;

   localparam logic [31:0] ID_SEGMENT       = 32'h1853_8067;
   localparam logic [31:0] ID_INFO          = 32'h1549_A966;
   localparam logic [31:0] ID_TRACKS        = 32'h1654_AE6B;
   localparam logic [31:0] ID_TRACKENTRY    = 32'h0000_00AE;
   localparam logic [31:0] ID_TIMECODESCALE = 32'h002A_D7B1;
   localparam logic [31:0] ID_DURATION      = 32'h0000_4489;
   localparam logic [31:0] ID_TRACKTYPE     = 32'h0000_0083;
   localparam logic [31:0] ID_TRACKNAME     = 32'h0000_536E;

   localparam logic [7:0]  VINT_TOP_MARKER  = 8'h80;
   localparam logic [31:0] SIZE_SATURATED   = 32'hFFFF_FFFF;
   localparam logic [31:0] DURATION_FLOAT_BYTES = 32'd4;

   // varint length from the first byte, nine for a zero byte
   function automatic logic [3:0] vint_len(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd9;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            n = 4'(8 - i);
         end
      end
      return n;
   endfunction

endpackage

// ===== rtl/ebml_element_stream_parser_top.sv =====
// top level of the ebml element stream parser
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_data_byte
//  rsp     | out       | rsp_valid/rsp_stall | id, size, value, kind, video name flag
//  csr     | in        | csr_valid/csr_ready | csr_video_track_code
//
// one byte per cycle sustained while rsp_stall is low; a byte and its result pass through the
// input register, one pass of decode logic and the result register
// synchronous reset clears the parser state and sets the video track code to one
// req_stall rises only while the result register is full and rsp_stall is high
// after a malformed varint all further bytes are swallowed until reset
module ebml_element_stream_parser_top #(
   parameter int MAX_VARINT_BYTES = 8,
   parameter int VALUE_BYTES      = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hdr_id,
   output logic [31:0] rsp_payload_size,
   output logic [31:0] rsp_element_value,
   output logic [2:0]  rsp_kind,
   output logic        rsp_is_video_name,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_video_track_code
);

   logic                 csr_write;
   logic [7:0]           video_code_ff;
   logic                 item_valid;
   logic [7:0]           item_byte;
   logic                 take;
   logic                 advance;
   logic                 res_valid;
   ebml_pkg::result_type res;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         video_code_ff <= 8'd1;
      end else if (csr_write) begin
         video_code_ff <= csr_video_track_code;
      end
   end

   ebml_input_stage u_input (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .take          (take),
      .item_valid    (item_valid),
      .item_byte     (item_byte)
   );

   ebml_parse_core #(
      .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
      .VALUE_BYTES      (VALUE_BYTES)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item_byte        (item_byte),
      .advance          (advance),
      .video_track_code (video_code_ff),
      .take             (take),
      .res_valid        (res_valid),
      .res              (res)
   );

   ebml_output_stage u_output (
      .clock             (clock),
      .reset             (reset),
      .load_valid        (res_valid),
      .load_res          (res),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hdr_id        (rsp_hdr_id),
      .rsp_payload_size  (rsp_payload_size),
      .rsp_element_value (rsp_element_value),
      .rsp_kind          (rsp_kind),
      .rsp_is_video_name (rsp_is_video_name)
   );

   a_stall_only_on_full_output: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall)
   ) else $error("input stalled while result register could move");

   a_error_fields_clear: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == ebml_pkg::KIND_ERROR) |->
         (rsp_payload_size == 32'd0 && rsp_element_value == 32'd0 && !rsp_is_video_name)
   ) else $error("error item carries payload fields");

   a_video_name_only_on_trackname: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_video_name) |->
         (rsp_kind == ebml_pkg::KIND_SKIPPED && rsp_hdr_id == ebml_pkg::ID_TRACKNAME)
   ) else $error("video name flag on wrong element");

   a_silent_after_error: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_kind == ebml_pkg::KIND_ERROR) |=> !rsp_valid
   ) else $error("item emitted after parser stopped");

endmodule

// ===== rtl/ebml_input_stage.sv =====
// input register holding one stream byte for the parse core
module ebml_input_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       take,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_stall  = valid_ff && !take;
   assign accept     = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_data_byte;
      end
   end

endmodule

// ===== rtl/ebml_parse_core.sv =====
// element header and payload value decoder: parser state and the single-pass step logic
module ebml_parse_core #(
   parameter int MAX_VARINT_BYTES = 8,
   parameter int VALUE_BYTES      = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  logic [7:0]             item_byte,
   input  logic                   advance,
   input  logic [7:0]             video_track_code,
   output logic                   take,
   output logic                   res_valid,
   output ebml_pkg::result_type   res
);

   localparam int VLW = $clog2(MAX_VARINT_BYTES);
   localparam int VCW = $clog2(VALUE_BYTES + 1);

   typedef enum logic [2:0] {
      PHASE_ID      = 3'b001,
      PHASE_SIZE    = 3'b010,
      PHASE_PAYLOAD = 3'b100
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [31:0]     id_ff, id_in;
   logic [31:0]     size_ff, size_in;
   logic [VLW-1:0]  vleft_ff, vleft_in;
   logic [31:0]     payload_left_ff, payload_left_in;
   logic [31:0]     value_ff, value_in;
   logic [VCW-1:0]  vcnt_ff, vcnt_in;
   logic [7:0]      trk_code_ff, trk_code_in;
   logic            stopped_ff, stopped_in;

   assign take = item_valid && advance;

   always_comb begin
      logic [3:0]  vlen;
      logic [7:0]  marker;
      logic        bad_start;
      logic        hdr;
      logic        fin;
      logic        err;
      logic [31:0] fin_v;

      phase_in        = phase_ff;
      id_in           = id_ff;
      size_in         = size_ff;
      vleft_in        = vleft_ff;
      payload_left_in = payload_left_ff;
      value_in        = value_ff;
      vcnt_in         = vcnt_ff;
      trk_code_in     = trk_code_ff;
      stopped_in      = stopped_ff;
      res_valid       = 1'b0;
      res             = '0;
      res.kind        = ebml_pkg::KIND_SKIPPED;

      vlen      = ebml_pkg::vint_len(item_byte);
      marker    = ebml_pkg::VINT_TOP_MARKER >> (vlen - 4'd1);
      bad_start = (item_byte == 8'd0) || (vlen > 4'(MAX_VARINT_BYTES));
      hdr       = 1'b0;
      fin       = 1'b0;
      err       = 1'b0;
      fin_v     = '0;

      if (item_valid && !stopped_ff) begin
         unique case (phase_ff)
            PHASE_PAYLOAD: begin
               if (vcnt_ff < VCW'(VALUE_BYTES)) begin
                  value_in = {value_ff[23:0], item_byte};
                  vcnt_in  = vcnt_ff + VCW'(1);
               end
               payload_left_in = payload_left_ff - 32'd1;
               if (payload_left_in == 32'd0) begin
                  fin   = 1'b1;
                  fin_v = value_in;
               end
            end
            PHASE_SIZE: begin
               if (vleft_ff == '0) begin
                  if (bad_start) begin
                     err = 1'b1;
                  end else begin
                     size_in  = {24'd0, item_byte & ~marker};
                     vleft_in = VLW'(vlen - 4'd1);
                     hdr      = (vleft_in == '0);
                  end
               end else begin
                  size_in  = (size_ff[31:24] != 8'd0) ? ebml_pkg::SIZE_SATURATED
                                                       : {size_ff[23:0], item_byte};
                  vleft_in = vleft_ff - VLW'(1);
                  hdr      = (vleft_in == '0);
               end
            end
            default: begin
               phase_in = PHASE_ID;
               if (vleft_ff == '0) begin
                  id_in = '0;
                  if (bad_start) begin
                     err = 1'b1;
                  end else begin
                     id_in    = {24'd0, item_byte};
                     vleft_in = VLW'(vlen - 4'd1);
                  end
               end else begin
                  id_in    = {id_ff[23:0], item_byte};
                  vleft_in = vleft_ff - VLW'(1);
               end
               if (!err && vleft_in == '0) begin
                  phase_in = PHASE_SIZE;
                  size_in  = '0;
               end
            end
         endcase

         if (err) begin
            stopped_in       = 1'b1;
            res_valid        = 1'b1;
            res.hdr_id       = id_in;
            res.kind         = ebml_pkg::KIND_ERROR;
         end

         if (hdr) begin
            if (id_in == ebml_pkg::ID_SEGMENT || id_in == ebml_pkg::ID_INFO ||
                id_in == ebml_pkg::ID_TRACKS || id_in == ebml_pkg::ID_TRACKENTRY) begin
               phase_in         = PHASE_ID;
               res_valid        = 1'b1;
               res.hdr_id       = id_in;
               res.payload_size = size_in;
               res.kind         = ebml_pkg::KIND_CONTAINER;
            end else begin
               value_in = '0;
               vcnt_in  = '0;
               if (size_in == 32'd0) begin
                  fin   = 1'b1;
                  fin_v = '0;
               end else begin
                  payload_left_in = size_in;
                  phase_in        = PHASE_PAYLOAD;
               end
            end
         end

         if (fin) begin
            phase_in         = PHASE_ID;
            payload_left_in  = '0;
            vleft_in         = '0;
            res_valid        = 1'b1;
            res.hdr_id       = id_in;
            res.payload_size = size_in;
            unique case (id_in)
               ebml_pkg::ID_TIMECODESCALE: begin
                  res.kind          = ebml_pkg::KIND_UNSIGNED;
                  res.element_value = fin_v;
               end
               ebml_pkg::ID_TRACKTYPE: begin
                  res.kind          = ebml_pkg::KIND_UNSIGNED;
                  res.element_value = fin_v;
                  trk_code_in       = fin_v[7:0];
               end
               ebml_pkg::ID_DURATION: begin
                  res.kind          = ebml_pkg::KIND_FLOAT;
                  res.element_value = (size_in == ebml_pkg::DURATION_FLOAT_BYTES) ? fin_v : '0;
               end
               ebml_pkg::ID_TRACKNAME: begin
                  res.is_video_name = (trk_code_ff == video_track_code);
               end
               default: begin
                  res.kind = ebml_pkg::KIND_SKIPPED;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_ID;
         id_ff           <= '0;
         size_ff         <= '0;
         vleft_ff        <= '0;
         payload_left_ff <= '0;
         value_ff        <= '0;
         vcnt_ff         <= '0;
         trk_code_ff     <= '0;
         stopped_ff      <= 1'b0;
      end else if (take) begin
         phase_ff        <= phase_in;
         id_ff           <= id_in;
         size_ff         <= size_in;
         vleft_ff        <= vleft_in;
         payload_left_ff <= payload_left_in;
         value_ff        <= value_in;
         vcnt_ff         <= vcnt_in;
         trk_code_ff     <= trk_code_in;
         stopped_ff      <= stopped_in;
      end
   end

endmodule

// ===== rtl/ebml_output_stage.sv =====
// result register towards the response channel
module ebml_output_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  ebml_pkg::result_type  load_res,
   output logic                  advance,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_hdr_id,
   output logic [31:0]           rsp_payload_size,
   output logic [31:0]           rsp_element_value,
   output logic [2:0]            rsp_kind,
   output logic                  rsp_is_video_name
);

   logic                 valid_ff;
   ebml_pkg::result_type res_ff;

   assign advance           = !valid_ff || !rsp_stall;
   assign rsp_valid         = valid_ff;
   assign rsp_hdr_id        = res_ff.hdr_id;
   assign rsp_payload_size  = res_ff.payload_size;
   assign rsp_element_value = res_ff.element_value;
   assign rsp_kind          = res_ff.kind;
   assign rsp_is_video_name = res_ff.is_video_name;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_valid) begin
         res_ff <= load_res;
      end
   end

endmodule
